// ----- sv/strc_pkg.sv -----
package strc_pkg;

   // Fixed datapath widths that follow from the Q formats of the fields.
   localparam int GAIN_W     = 16;
   localparam int CSR_W      = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int MASK_W     = 3;
   localparam int GAIN_SLOTS = 3;
   localparam int RAD_W      = 48;
   localparam int ROOT_W     = 24;
   localparam int PROD_W     = 40;
   localparam int QUO_W      = 40;
   localparam int ROOT_STEPS = 24;
   localparam int DIV_STEPS  = 40;
   localparam int CNT_W      = 6;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_LOAD   = 2'd1,
      OP_CLEAR  = 2'd2
   } strc_op_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_NOT_CONFIGURED = 3'd1,
      ST_BAD_AXIS       = 3'd2,
      ST_BAD_DT         = 3'd3,
      ST_NUMERIC        = 3'd4
   } strc_status_type;

   typedef enum logic [1:0] {
      CSR_LAMBDA1 = 2'd0,
      CSR_LAMBDA2 = 2'd1,
      CSR_GAIN    = 2'd2,
      CSR_MASK    = 2'd3
   } strc_csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_ROOT,
      S_MUL_CORR,
      S_MUL_DELTA,
      S_SUM,
      S_DIV,
      S_NORM,
      S_FINISH
   } strc_state_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic check;
      logic root_step;
      logic mul_corr;
      logic mul_delta;
      logic sum;
      logic div_step;
      logic norm;
      logic finish;
   } strc_cmd_type;

   // Status from the datapath back to the sequencer.
   typedef struct packed {
      logic run;
      logic corr_ovf;
      logic sum_ovf;
   } strc_stat_type;

endpackage

// ----- sv/strc_ctrl.sv -----
module strc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  strc_pkg::strc_stat_type stat,
   output strc_pkg::strc_cmd_type  cmd
);
   import strc_pkg::*;

   strc_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              rsp_valid_ff;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (req_valid) state_in = S_CHECK;
         S_CHECK:     state_in = stat.run ? S_ROOT : S_FINISH;
         S_ROOT:      if (cnt_ff == '0) state_in = S_MUL_CORR;
         S_MUL_CORR:  state_in = stat.corr_ovf ? S_FINISH : S_MUL_DELTA;
         S_MUL_DELTA: state_in = S_SUM;
         S_SUM:       state_in = stat.sum_ovf ? S_FINISH : S_DIV;
         S_DIV:       if (cnt_ff == '0) state_in = S_NORM;
         S_NORM:      state_in = S_FINISH;
         S_FINISH:    if (slot_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:      cmd.capture   = req_valid;
         S_CHECK:     cmd.check     = 1'b1;
         S_ROOT:      cmd.root_step = 1'b1;
         S_MUL_CORR:  cmd.mul_corr  = 1'b1;
         S_MUL_DELTA: cmd.mul_delta = 1'b1;
         S_SUM:       cmd.sum       = 1'b1;
         S_DIV:       cmd.div_step  = 1'b1;
         S_NORM:      cmd.norm      = 1'b1;
         S_FINISH:    cmd.finish    = slot_free;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CHECK) begin
            cnt_ff <= CNT_W'(ROOT_STEPS - 1);
         end else if (state_ff == S_SUM) begin
            cnt_ff <= CNT_W'(DIV_STEPS - 1);
         end else if ((state_ff == S_ROOT) || (state_ff == S_DIV)) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written while the output register was still occupied");
   a_capture_check: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_CHECK))
      else $error("accepted transaction was not checked in the next cycle");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DIV) && (cnt_ff == '0)) |=> (state_ff == S_NORM))
      else $error("divider did not hand over to normalization");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result appeared outside the finish step");
`endif

endmodule

// ----- sv/strc_dp.sv -----
module strc_dp #(
   parameter int AXES = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  strc_pkg::strc_cmd_type        cmd,
   output strc_pkg::strc_stat_type       stat,
   input  logic [1:0]                    req_cmd,
   input  logic [2:0]                    req_axis,
   input  logic signed [31:0]            req_rate,
   input  logic signed [31:0]            req_rate_setpoint,
   input  logic [23:0]                   req_time_step,
   input  logic signed [31:0]            req_load_value,
   input  logic [strc_pkg::CSR_W-1:0]    lambda1_all,
   input  logic [strc_pkg::CSR_W-1:0]    lambda2_all,
   input  logic [strc_pkg::CSR_W-1:0]    gain_all,
   input  logic [strc_pkg::MASK_W-1:0]   cfg_mask,
   output logic [2:0]                    rsp_status,
   output logic signed [31:0]            rsp_sliding_var,
   output logic signed [31:0]            rsp_accel_cmd,
   output logic signed [31:0]            rsp_raw_output,
   output logic signed [31:0]            rsp_next_integrator
);
   import strc_pkg::*;

   localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

   // Captured transaction.
   logic [1:0]          cmd_ff;
   logic [2:0]          axis_ff;
   logic [32:0]         s_ff;
   logic [23:0]         dt_ff;
   logic [31:0]         load_ff;
   strc_status_type     st_ff;
   logic [31:0]         nu_ff;

   // Integrator store, one word per axis.
   logic [31:0]         integ_ff [AXES];

   // Square root, divider and intermediate results.
   logic [RAD_W-1:0]    rad_ff;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [ROOT_W+1:0]   srem_ff, srem_in;
   logic [30:0]         corr_ff;
   logic [23:0]         delta_ff;
   logic [31:0]         a_ff, nn_ff, c_ff;
   logic                neg_ff;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [GAIN_W-1:0]   drem_ff, drem_in;

   // Output register.
   logic [2:0]          rsp_status_ff;
   logic [31:0]         rsp_s_ff, rsp_a_ff, rsp_c_ff, rsp_nn_ff;

   logic [IDX_W-1:0]    idx;
   logic                ax_ok, cfg_ok, s_fits;
   logic [GAIN_W-1:0]   l1_sel, l2_sel, g_sel;
   strc_status_type     chk_status;
   logic [31:0]         s_mag;
   logic [ROOT_W+3:0]   srem_sh, strial, sdiff;
   logic                sq_ge;
   logic [ROOT_W-1:0]   mul_a;
   logic [GAIN_W-1:0]   mul_b;
   logic [PROD_W-1:0]   prod;
   logic                s_pos, s_neg;
   logic [33:0]         nu_x, a_sum, nn_sum;
   logic                a_fits, nn_fits;
   logic [31:0]         a_mag;
   logic [GAIN_W:0]     drem_sh, ddiff;
   logic                d_ge;
   logic                quo_ovf;
   logic [QUO_W-1:0]    quo_neg;
   logic                ok, upd_ok, load_ok;

   assign idx    = axis_ff[IDX_W-1:0];
   assign ax_ok  = (4'(axis_ff) < 4'(AXES));
   assign cfg_ok = (axis_ff < 3'(GAIN_SLOTS)) && cfg_mask[axis_ff[1:0]];
   assign s_fits = (s_ff[32] == s_ff[31]);

   // Gains of the addressed axis; axes past the packed slots read zero.
   always_comb begin
      case (axis_ff)
         3'd0: begin
            l1_sel = lambda1_all[15:0];
            l2_sel = lambda2_all[15:0];
            g_sel  = gain_all[15:0];
         end
         3'd1: begin
            l1_sel = lambda1_all[31:16];
            l2_sel = lambda2_all[31:16];
            g_sel  = gain_all[31:16];
         end
         3'd2: begin
            l1_sel = lambda1_all[47:32];
            l2_sel = lambda2_all[47:32];
            g_sel  = gain_all[47:32];
         end
         default: begin
            l1_sel = '0;
            l2_sel = '0;
            g_sel  = '0;
         end
      endcase
   end

   always_comb begin
      case (cmd_ff)
         OP_UPDATE: begin
            if (!ax_ok) begin
               chk_status = ST_BAD_AXIS;
            end else if (!cfg_ok) begin
               chk_status = ST_NOT_CONFIGURED;
            end else if (dt_ff == '0) begin
               chk_status = ST_BAD_DT;
            end else if (!s_fits || (g_sel == '0)) begin
               chk_status = ST_NUMERIC;
            end else begin
               chk_status = ST_OK;
            end
         end
         OP_LOAD: chk_status = ax_ok ? ST_OK : ST_BAD_AXIS;
         default: chk_status = ST_OK;
      endcase
   end

   assign stat.run = (cmd_ff == OP_UPDATE) && (chk_status == ST_OK);

   assign s_mag = 32'(s_ff[32] ? -s_ff : s_ff);

   // One root bit per step, restoring form.
   assign srem_sh = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign strial  = {2'b00, root_ff, 2'b01};
   assign sq_ge   = (srem_sh >= strial);
   assign sdiff   = srem_sh - strial;
   assign root_in = {root_ff[ROOT_W-2:0], sq_ge};
   assign srem_in = sq_ge ? sdiff[ROOT_W+1:0] : srem_sh[ROOT_W+1:0];

   // One shared multiplier for the correction and the integral step.
   assign mul_a = cmd.mul_corr ? root_ff : dt_ff;
   assign mul_b = cmd.mul_corr ? l1_sel : l2_sel;
   assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign stat.corr_ovf = prod[PROD_W-1];

   assign s_neg  = s_ff[32];
   assign s_pos  = !s_ff[32] && (s_ff != '0);
   assign nu_x   = {{2{nu_ff[31]}}, nu_ff};
   assign a_sum  = s_pos ? (nu_x - {3'b000, corr_ff}) :
                   s_neg ? (nu_x + {3'b000, corr_ff}) : nu_x;
   assign nn_sum = s_pos ? (nu_x - {10'd0, delta_ff}) :
                   s_neg ? (nu_x + {10'd0, delta_ff}) : nu_x;
   assign a_fits  = (a_sum[33:31] == 3'b000) || (a_sum[33:31] == 3'b111);
   assign nn_fits = (nn_sum[33:31] == 3'b000) || (nn_sum[33:31] == 3'b111);
   assign stat.sum_ovf = !a_fits || !nn_fits;
   assign a_mag = 32'(a_sum[33] ? -a_sum : a_sum);

   // One quotient bit per step, restoring form on the magnitude.
   assign drem_sh = {drem_ff, quo_ff[QUO_W-1]};
   assign d_ge    = (drem_sh >= {1'b0, g_sel});
   assign ddiff   = drem_sh - {1'b0, g_sel};
   assign drem_in = d_ge ? ddiff[GAIN_W-1:0] : drem_sh[GAIN_W-1:0];
   assign quo_in  = {quo_ff[QUO_W-2:0], d_ge};
   assign quo_neg = -quo_ff;
   assign quo_ovf = neg_ff ? ((quo_ff[QUO_W-1:32] != '0) ||
                              (quo_ff[31] && (quo_ff[30:0] != '0)))
                           : (quo_ff[QUO_W-1:31] != '0);

   assign ok      = (st_ff == ST_OK);
   assign upd_ok  = ok && (cmd_ff == OP_UPDATE);
   assign load_ok = ok && (cmd_ff == OP_LOAD);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_cmd;
         axis_ff <= req_axis;
         s_ff    <= {req_rate[31], req_rate} - {req_rate_setpoint[31], req_rate_setpoint};
         dt_ff   <= req_time_step;
         load_ff <= req_load_value;
      end
      if (cmd.check) begin
         st_ff   <= chk_status;
         nu_ff   <= ax_ok ? integ_ff[idx] : '0;
         rad_ff  <= {s_mag, 16'd0};
         root_ff <= '0;
         srem_ff <= '0;
      end
      if (cmd.root_step) begin
         root_ff <= root_in;
         srem_ff <= srem_in;
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
      end
      if (cmd.mul_corr) begin
         corr_ff <= prod[PROD_W-2:8];
         if (stat.corr_ovf) st_ff <= ST_NUMERIC;
      end
      if (cmd.mul_delta) begin
         delta_ff <= prod[PROD_W-1:16];
      end
      if (cmd.sum) begin
         a_ff    <= a_sum[31:0];
         nn_ff   <= nn_sum[31:0];
         neg_ff  <= a_sum[33];
         quo_ff  <= {a_mag, 8'd0};
         drem_ff <= '0;
         if (stat.sum_ovf) st_ff <= ST_NUMERIC;
      end
      if (cmd.div_step) begin
         quo_ff  <= quo_in;
         drem_ff <= drem_in;
      end
      if (cmd.norm) begin
         c_ff <= neg_ff ? quo_neg[31:0] : quo_ff[31:0];
         if (quo_ovf) st_ff <= ST_NUMERIC;
      end
      if (cmd.finish) begin
         rsp_status_ff <= st_ff;
         rsp_s_ff      <= upd_ok ? s_ff[31:0] : '0;
         rsp_a_ff      <= upd_ok ? a_ff : '0;
         rsp_c_ff      <= upd_ok ? c_ff : '0;
         rsp_nn_ff     <= upd_ok ? nn_ff : (load_ok ? load_ff : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) integ_ff[i] <= '0;
      end else if (cmd.finish) begin
         if (upd_ok) begin
            integ_ff[idx] <= nn_ff;
         end else if (load_ok) begin
            integ_ff[idx] <= load_ff;
         end else if (ok && (cmd_ff == OP_CLEAR)) begin
            for (int i = 0; i < AXES; i++) integ_ff[i] <= '0;
         end
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_sliding_var     = rsp_s_ff;
   assign rsp_accel_cmd       = rsp_a_ff;
   assign rsp_raw_output      = rsp_c_ff;
   assign rsp_next_integrator = rsp_nn_ff;

`ifndef SYNTHESIS
   a_ok_axis: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && (upd_ok || load_ok)) |-> ax_ok)
      else $error("integrator commit addressed an axis that does not exist");
   a_norm_sign: assert property (@(posedge clock) disable iff (reset)
      (cmd.norm && !quo_ovf && (quo_ff != '0)) |=> (c_ff[31] == neg_ff))
      else $error("quotient sign does not follow the dividend sign");
   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |-> (srem_in <= {1'b0, root_in, 1'b0}))
      else $error("square root remainder exceeds twice the partial root");
`endif

endmodule

// ----- sv/super_twisting_rate_controller.sv -----
// An update runs through check, 24 root steps, two multiplies, sum, 40 divide steps,
// normalize and the output write; an overflow found at the correction multiply or the
// sum ends it at the output write. Other transactions go from check to the output write.
// The root and divide are bit-serial, and a new transaction is accepted only when idle;
// the next one may be accepted while a result waits in the output register.
// Synchronous reset zeroes the control registers and integrators and drops the result valid.
module super_twisting_rate_controller #(
   parameter int AXES = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_cmd,
   input  logic [2:0]                         req_axis,
   input  logic signed [31:0]                 req_rate,
   input  logic signed [31:0]                 req_rate_setpoint,
   input  logic [23:0]                        req_time_step,
   input  logic signed [31:0]                 req_load_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic signed [31:0]                 rsp_sliding_var,
   output logic signed [31:0]                 rsp_accel_cmd,
   output logic signed [31:0]                 rsp_raw_output,
   output logic signed [31:0]                 rsp_next_integrator,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [strc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [strc_pkg::CSR_W-1:0]         csr_wdata
);
   import strc_pkg::*;

   // Configuration registers. Each gain register packs one Q8.8 value per axis, axis 0
   // in the low 16 bits. Writes must only be issued while the block is idle, which the
   // block does not enforce; the datapath reads these directly all through a transaction.
   logic [CSR_W-1:0]  lambda1_ff;
   logic [CSR_W-1:0]  lambda2_ff;
   logic [CSR_W-1:0]  gain_ff;
   logic [MASK_W-1:0] mask_ff;

   strc_cmd_type  cmd;
   strc_stat_type stat;

   // The configuration port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda1_ff <= '0;
         lambda2_ff <= '0;
         gain_ff    <= '0;
         mask_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LAMBDA1: lambda1_ff <= csr_wdata;
            CSR_LAMBDA2: lambda2_ff <= csr_wdata;
            CSR_GAIN:    gain_ff    <= csr_wdata;
            CSR_MASK:    mask_ff    <= csr_wdata[MASK_W-1:0];
            default:     mask_ff    <= mask_ff;
         endcase
      end
   end

   // The sequencer walks an update through check, root, multiply, sum, divide, normalize
   // and finish, others via check and finish; it owns the request and result handshakes.
   strc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the captured transaction, the per-axis integrators, the shared
   // square root and divide registers, the single multiplier and the output register.
   strc_dp #(
      .AXES (AXES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_cmd             (req_cmd),
      .req_axis            (req_axis),
      .req_rate            (req_rate),
      .req_rate_setpoint   (req_rate_setpoint),
      .req_time_step       (req_time_step),
      .req_load_value      (req_load_value),
      .lambda1_all         (lambda1_ff),
      .lambda2_all         (lambda2_ff),
      .gain_all            (gain_ff),
      .cfg_mask            (mask_ff),
      .rsp_status          (rsp_status),
      .rsp_sliding_var     (rsp_sliding_var),
      .rsp_accel_cmd       (rsp_accel_cmd),
      .rsp_raw_output      (rsp_raw_output),
      .rsp_next_integrator (rsp_next_integrator)
   );

endmodule
